/* rtl/ced_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ced_pkg
// Shared constants, types and compass mask tables for the 3x3 compass edge
// detector.
// ----------------------------------------------------------------------------
package ced_pkg;

   // Field and port widths
   localparam int PIXEL_W     = 8;
   localparam int EDGE_W      = 8;
   localparam int CENTER_W    = 10;
   localparam int KIND_W      = 2;
   localparam int SIZE_W      = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int RSP_DATA_W  = 32;

   // Default frame limits
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MIN_SIZE       = 3;

   // Datapath sizing
   localparam int NUM_DIRS = 8;
   localparam int NUM_TAPS = 9;
   localparam int NUM_ROWS = 3;
   localparam int PROD_W   = 13;
   localparam int PART_W   = 13;
   localparam int SUM_W    = 14;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OPERATOR_KIND    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LEVEL       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DEPTH_MODE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT     = 3'd5;

   // Mask set codes
   localparam logic [KIND_W-1:0] KIND_KIRSCH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PREWITT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SOBEL   = 2'd2;

   // Register reset values
   localparam logic [KIND_W-1:0] RST_OPERATOR_KIND = KIND_SOBEL;
   localparam logic [EDGE_W-1:0] RST_HIGH_LEVEL    = 8'd100;
   localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;

   // Clip values and output levels per pixel depth
   localparam logic [EDGE_W-1:0] CLIP_8BIT = 8'd255;
   localparam logic [EDGE_W-1:0] CLIP_4BIT = 8'd16;
   localparam logic [EDGE_W-1:0] HIGH_8BIT = 8'd250;
   localparam logic [EDGE_W-1:0] LOW_8BIT  = 8'd16;
   localparam logic [EDGE_W-1:0] HIGH_4BIT = 8'd10;
   localparam logic [EDGE_W-1:0] LOW_4BIT  = 8'd3;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic signed [3:0]  coef_type;

   // Position data that travels with each request down the pipe
   typedef struct packed {
      logic                last;
      logic [CENTER_W-1:0] row;
      logic [CENTER_W-1:0] col;
   } meta_type;

   // Mask coefficients
   localparam coef_type P5 = 4'sd5;
   localparam coef_type P2 = 4'sd2;
   localparam coef_type P1 = 4'sd1;
   localparam coef_type Z0 = 4'sd0;
   localparam coef_type N1 = -4'sd1;
   localparam coef_type N2 = -4'sd2;
   localparam coef_type N3 = -4'sd3;

   // [set][direction][tap], taps row-major, tap 0 oldest row and column
   localparam coef_type MASKS [3][NUM_DIRS][NUM_TAPS] = '{
      '{ // Kirsch
         '{P5, P5, P5, N3, Z0, N3, N3, N3, N3},
         '{N3, P5, P5, N3, Z0, P5, N3, N3, N3},
         '{N3, N3, P5, N3, Z0, P5, N3, N3, P5},
         '{N3, N3, N3, N3, Z0, P5, N3, P5, P5},
         '{N3, N3, N3, N3, Z0, N3, P5, P5, P5},
         '{N3, N3, N3, P5, Z0, N3, P5, P5, N3},
         '{P5, N3, N3, P5, Z0, N3, P5, N3, N3},
         '{P5, P5, N3, P5, Z0, N3, N3, N3, N3}},
      '{ // Prewitt
         '{P1, P1, P1, P1, N2, P1, N1, N1, N1},
         '{P1, P1, P1, P1, N2, N1, P1, N1, N1},
         '{P1, P1, N1, P1, N2, N1, P1, P1, N1},
         '{P1, N1, N1, P1, N2, N1, P1, P1, P1},
         '{N1, N1, N1, P1, N2, P1, P1, P1, P1},
         '{N1, N1, P1, N1, N2, P1, P1, P1, P1},
         '{N1, P1, P1, N1, N2, P1, N1, P1, P1},
         '{P1, P1, P1, N1, N2, P1, N1, N1, P1}},
      '{ // Sobel
         '{P1, P2, P1, Z0, Z0, Z0, N1, N2, N1},
         '{P2, P1, Z0, P1, Z0, N1, Z0, N1, N2},
         '{P1, Z0, N1, P2, Z0, N2, P1, Z0, N1},
         '{Z0, N1, N2, P1, Z0, N1, P2, P1, Z0},
         '{N1, N2, N1, Z0, Z0, Z0, P1, P2, P1},
         '{N2, N1, Z0, N1, Z0, P1, Z0, P1, P2},
         '{N1, Z0, P1, N2, Z0, P2, N1, Z0, P1},
         '{Z0, P1, P2, N1, Z0, P1, N2, N1, Z0}}
   };

   // Coefficient lookup; the unused set code gives all-zero masks
   function automatic coef_type mask_coef(input logic [KIND_W-1:0] kind,
                                          input logic [2:0]        dir,
                                          input logic [3:0]        tap);
      coef_type c;
      c = Z0;
      case (kind)
         KIND_KIRSCH:  c = MASKS[0][dir][tap];
         KIND_PREWITT: c = MASKS[1][dir][tap];
         KIND_SOBEL:   c = MASKS[2][dir][tap];
         default:      c = Z0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/ced_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ced_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ced_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/compass_edge_detector_3x3.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// compass_edge_detector_3x3
// Kirsch / Prewitt / Sobel compass edge strength over a sliding 3x3 window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per clock while req_tready is
// high; it drops while the skid entry is full. Each pixel costs one read
// and one write on each of the two line-store RAMs, whose separate ports
// serve one pixel per cycle. A result for an interior center is presented
// on the result port after its pixel is accepted, through five register
// stages (line-store read, window, partial sums, clamp, then max and
// threshold into the output register); border pixels produce nothing. A
// two-entry output stage (register plus skid) lets the input keep flowing
// while a result waits. The line stores are not cleared after reset; they
// are filled by the first two rows of a frame before any result reads
// them. Configuration must only be written while no request is in flight.
// Sizes below 3 or above the MAX_ limits are saturated.
// ----------------------------------------------------------------------------
module compass_edge_detector_3x3
   import ced_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // Pixel requests
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   input  wire logic                   req_tuser,   // [0] frame_start
   // Results
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [7:0] edge_value,
                                                    // [17:8] center_row,
                                                    // [27:18] center_col,
                                                    // [31:28] zero
   output logic                        rsp_tlast    // frame_last
);

   // Counter and size widths
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int HW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HHW = $clog2(MAX_HEIGHT + 1);
   localparam int SWW = (WW > SIZE_W) ? WW : SIZE_W;
   localparam int SHW = (HHW > SIZE_W) ? HHW : SIZE_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [KIND_W-1:0] op_kind_ff;
   logic              thr_en_ff;
   logic [EDGE_W-1:0] high_level_ff;
   logic              depth_mode_ff;
   logic [SIZE_W-1:0] img_width_ff;
   logic [SIZE_W-1:0] img_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_kind_ff    <= RST_OPERATOR_KIND;
         thr_en_ff     <= 1'b0;
         high_level_ff <= RST_HIGH_LEVEL;
         depth_mode_ff <= 1'b0;
         img_width_ff  <= RST_IMAGE_WIDTH;
         img_height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPERATOR_KIND:    op_kind_ff    <= csr_wdata[KIND_W-1:0];
            CSR_THRESHOLD_ENABLE: thr_en_ff     <= csr_wdata[0];
            CSR_HIGH_LEVEL:       high_level_ff <= csr_wdata[EDGE_W-1:0];
            CSR_PIXEL_DEPTH_MODE: depth_mode_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH:      img_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:     img_height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size, saturated to the supported range
   logic [SWW-1:0] width_ext;
   logic [SHW-1:0] height_ext;
   logic [WW-1:0]  width_eff;
   logic [HHW-1:0] height_eff;

   always_comb begin
      width_ext  = SWW'(img_width_ff);
      height_ext = SHW'(img_height_ff);
      if (width_ext < SWW'(MIN_SIZE)) begin
         width_eff = WW'(MIN_SIZE);
      end else if (width_ext > SWW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ext);
      end
      if (height_ext < SHW'(MIN_SIZE)) begin
         height_eff = HHW'(MIN_SIZE);
      end else if (height_ext > SHW'(MAX_HEIGHT)) begin
         height_eff = HHW'(MAX_HEIGHT);
      end else begin
         height_eff = HHW'(height_ext);
      end
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipe moves unless the skid entry is taken
   // ------------------------------------------------------------------
   logic skid_vld_ff;
   logic advance;
   logic accept;

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ------------------------------------------------------------------
   // Position counters (accept stage)
   // ------------------------------------------------------------------
   logic [AW-1:0]  col_ff, col_in, col_cur;
   logic [HW-1:0]  row_ff, row_in, row_cur;
   logic [WW-1:0]  col_p1;
   logic [HHW-1:0] row_p1;
   logic           produce;
   meta_type       meta_cur;

   always_comb begin
      col_cur = req_tuser ? '0 : col_ff;
      row_cur = req_tuser ? '0 : row_ff;
      col_p1  = WW'(col_cur) + WW'(1);
      row_p1  = HHW'(row_cur) + HHW'(1);

      produce = (row_cur >= HW'(2)) && (col_cur >= AW'(2)) &&
                (HHW'(row_cur) < height_eff) && (WW'(col_cur) < width_eff);

      meta_cur.row  = CENTER_W'(row_cur - HW'(1));
      meta_cur.col  = CENTER_W'(col_cur - AW'(1));
      meta_cur.last = (row_p1 == height_eff) && (col_p1 == width_eff);

      if (col_p1 >= width_eff) begin
         col_in = '0;
         row_in = (row_p1 >= height_eff) ? '0 : HW'(row_p1);
      end else begin
         col_in = AW'(col_p1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Line stores: read at accept, write back one stage later
   // ------------------------------------------------------------------
   logic            s1_vld_ff;
   logic            s1_prod_ff;
   logic [AW-1:0]   s1_col_ff;
   pixel_type       s1_px_ff;
   meta_type        s1_meta_ff;
   pixel_type       ram_a_rd, ram_b_rd;
   pixel_type       up1, up2;
   logic            line_wr;

   // Forwarding of the most recent line-store write
   logic            fwd_vld_ff;
   logic [AW-1:0]   fwd_addr_ff;
   pixel_type       fwd_a_ff, fwd_b_ff;
   logic            fwd_hit;

   assign line_wr = advance && s1_vld_ff;
   assign fwd_hit = fwd_vld_ff && (fwd_addr_ff == s1_col_ff);
   assign up1     = fwd_hit ? fwd_a_ff : ram_a_rd;
   assign up2     = fwd_hit ? fwd_b_ff : ram_b_rd;

   // Row above the current one
   ced_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_a_rd)
   );

   // Two rows above the current one
   ced_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_col_ff),
      .wr_data (up1),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_b_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= accept;
         if (s1_vld_ff) begin
            fwd_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= produce;
         s1_col_ff  <= col_cur;
         s1_px_ff   <= req_tdata;
         s1_meta_ff <= meta_cur;
         if (s1_vld_ff) begin
            fwd_addr_ff <= s1_col_ff;
            fwd_a_ff    <= s1_px_ff;
            fwd_b_ff    <= up1;
         end
      end
   end

   // ------------------------------------------------------------------
   // 3x3 window, shifted once per pixel
   // ------------------------------------------------------------------
   pixel_type window_ff [NUM_TAPS];
   logic      s2_prod_ff;
   meta_type  s2_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TAPS; i++) begin
            window_ff[i] <= '0;
         end
         s2_prod_ff <= 1'b0;
      end else if (advance) begin
         s2_prod_ff <= s1_vld_ff && s1_prod_ff;
         if (s1_vld_ff) begin
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[2] <= up2;
            window_ff[3] <= window_ff[4];
            window_ff[4] <= window_ff[5];
            window_ff[5] <= up1;
            window_ff[6] <= window_ff[7];
            window_ff[7] <= window_ff[8];
            window_ff[8] <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // ------------------------------------------------------------------
   // Per-row partial sums for each of the eight directions
   // ------------------------------------------------------------------
   logic signed [PART_W-1:0] part_in [NUM_DIRS][NUM_ROWS];
   logic signed [PART_W-1:0] part_ff [NUM_DIRS][NUM_ROWS];
   logic                     s3_prod_ff;
   meta_type                 s3_meta_ff;

   always_comb begin
      logic signed [PROD_W-1:0] px_s;
      logic signed [PROD_W-1:0] cf_s;
      coef_type                 cf;
      for (int d = 0; d < NUM_DIRS; d++) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            part_in[d][r] = '0;
            for (int c = 0; c < NUM_ROWS; c++) begin
               cf   = mask_coef(op_kind_ff, 3'(d), 4'(3 * r + c));
               px_s = $signed({{(PROD_W - PIXEL_W){1'b0}}, window_ff[3 * r + c]});
               cf_s = $signed({{(PROD_W - 4){cf[3]}}, cf});
               part_in[d][r] = part_in[d][r] + PART_W'(px_s * cf_s);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_prod_ff <= 1'b0;
      end else if (advance) begin
         s3_prod_ff <= s2_prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff    <= part_in;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // ------------------------------------------------------------------
   // Full sums, clamped to 0..clip
   // ------------------------------------------------------------------
   logic [EDGE_W-1:0] clip;
   logic [EDGE_W-1:0] clamp_in [NUM_DIRS];
   logic [EDGE_W-1:0] clamp_ff [NUM_DIRS];
   logic              s4_prod_ff;
   meta_type          s4_meta_ff;

   assign clip = depth_mode_ff ? CLIP_4BIT : CLIP_8BIT;

   always_comb begin
      logic signed [SUM_W-1:0] sum;
      for (int d = 0; d < NUM_DIRS; d++) begin
         sum = SUM_W'(part_ff[d][0]) + SUM_W'(part_ff[d][1]) + SUM_W'(part_ff[d][2]);
         if (sum < 0) begin
            clamp_in[d] = '0;
         end else if (sum > $signed({{(SUM_W - EDGE_W){1'b0}}, clip})) begin
            clamp_in[d] = clip;
         end else begin
            clamp_in[d] = EDGE_W'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_prod_ff <= 1'b0;
      end else if (advance) begin
         s4_prod_ff <= s3_prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         clamp_ff   <= clamp_in;
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // ------------------------------------------------------------------
   // Maximum over directions and optional threshold
   // ------------------------------------------------------------------
   logic [EDGE_W-1:0] best;
   logic [EDGE_W-1:0] edge_val;
   logic              push;

   always_comb begin
      best = '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (clamp_ff[d] > best) begin
            best = clamp_ff[d];
         end
      end
      if (!thr_en_ff) begin
         edge_val = best;
      end else if (best > high_level_ff) begin
         edge_val = depth_mode_ff ? HIGH_4BIT : HIGH_8BIT;
      end else begin
         edge_val = depth_mode_ff ? LOW_4BIT : LOW_8BIT;
      end
   end

   assign push = advance && s4_prod_ff;

   // ------------------------------------------------------------------
   // Output register with skid entry
   // ------------------------------------------------------------------
   logic              out_vld_ff;
   logic [EDGE_W-1:0] out_edge_ff, skid_edge_ff;
   meta_type          out_meta_ff, skid_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_ff <= push;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_edge_ff <= skid_edge_ff;
            out_meta_ff <= skid_meta_ff;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_edge_ff <= edge_val;
         out_meta_ff <= s4_meta_ff;
      end else if (push) begin
         skid_edge_ff <= edge_val;
         skid_meta_ff <= s4_meta_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - EDGE_W - 2 * CENTER_W){1'b0}},
                        out_meta_ff.col, out_meta_ff.row, out_edge_ff};
   assign rsp_tlast  = out_meta_ff.last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry valid while output register empty");

   // Thresholded results take only the level values
   a_thr_levels: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && thr_en_ff) |->
         (out_edge_ff == HIGH_8BIT || out_edge_ff == LOW_8BIT ||
          out_edge_ff == HIGH_4BIT || out_edge_ff == LOW_4BIT))
      else $error("thresholded result is not a level value");

   // Four-bit strength never exceeds its clip
   a_clip_4bit: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !thr_en_ff && depth_mode_ff) |-> (out_edge_ff <= CLIP_4BIT))
      else $error("four-bit strength above clip");

   // An accepted pixel always reaches the line-store write-back stage
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      (accept) |=> s1_vld_ff)
      else $error("accepted pixel missing from line-store stage");

endmodule
`default_nettype wire
